[design/efaf_pkg.sv]
// Shared types and constants for the egress frame allow filter.
package efaf_pkg;

  // Byte offsets saturate at this value; a byte seen there has no known position.
  localparam logic [15:0] OFFSET_LIMIT = 16'hFFFF;

  localparam logic [15:0] ETH_HDR_LEN = 16'd14;
  localparam logic [15:0] IP_HDR_MIN  = 16'd20;
  localparam logic [15:0] TCP_HDR_LEN = 16'd20;
  localparam logic [15:0] UDP_HDR_LEN = 16'd8;

  localparam logic [15:0] POS_KIND_HI = 16'd12;
  localparam logic [15:0] POS_KIND_LO = 16'd13;
  localparam logic [15:0] POS_IHL     = 16'd14;
  localparam logic [15:0] POS_PROTO   = 16'd23;
  localparam logic [15:0] POS_DADDR_0 = 16'd30;
  localparam logic [15:0] POS_DADDR_3 = 16'd33;

  localparam logic [15:0] KIND_ARP  = 16'h0806;
  localparam logic [15:0] KIND_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [15:0] DNS_PORT  = 16'd53;

  typedef enum logic [2:0] {
    CLASS_ARP      = 3'd0,
    CLASS_TCP      = 3'd1,
    CLASS_UDP      = 3'd2,
    CLASS_OTHER_IP = 3'd3,
    CLASS_NON_IP   = 3'd4
  } efaf_class_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } efaf_item_t;

  typedef struct packed {
    logic [31:0] allowed_address;
    logic [15:0] allowed_port;
  } efaf_cfg_t;

endpackage

[design/efaf_cfg_regs.sv]
// Configuration register file with an APB-style access port.
module efaf_cfg_regs
  import efaf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output efaf_cfg_t   cfg
);

  localparam logic REG_ADDRESS = 1'b0;
  localparam logic REG_PORT    = 1'b1;

  logic [31:0] allowed_address_r;
  logic [15:0] allowed_port_r;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allowed_address_r <= '0;
      allowed_port_r    <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_ADDRESS: allowed_address_r <= pwdata;
        REG_PORT:    allowed_port_r    <= pwdata[15:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ADDRESS: prdata = allowed_address_r;
      REG_PORT:    prdata = {16'd0, allowed_port_r};
      default:     prdata = '0;
    endcase
  end

  assign cfg.allowed_address = allowed_address_r;
  assign cfg.allowed_port    = allowed_port_r;

endmodule

[design/efaf_in_buf.sv]
// Two-entry input buffer that keeps the input stall a registered signal.
module efaf_in_buf
  import efaf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  efaf_item_t in_item,
  output logic       head_valid,
  output efaf_item_t head_item,
  input  logic       pop
);

  logic [1:0] count_r;
  logic [1:0] count_nxt;
  efaf_item_t head_r;
  efaf_item_t tail_r;
  logic       push;

  assign in_stall   = (count_r == 2'd2);
  assign push       = in_valid & ~in_stall;
  assign head_valid = (count_r != 2'd0);
  assign head_item  = head_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Data moves toward the head; the tail only fills when the head entry stays occupied.
  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count_r == 2'd1) begin
        head_r <= in_item;
      end else begin
        head_r <= tail_r;
        tail_r <= in_item;
      end
    end else if (push) begin
      if (count_r == 2'd0) begin
        head_r <= in_item;
      end else begin
        tail_r <= in_item;
      end
    end else if (pop) begin
      head_r <= tail_r;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("input buffer count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != 2'd0)
    else $error("pop from an empty input buffer");

endmodule

[design/efaf_parse.sv]
// Header capture, verdict logic and the result register.
module efaf_parse
  import efaf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  efaf_cfg_t   cfg,
  input  logic        head_valid,
  input  efaf_item_t  head_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_pass_frame,
  output logic [2:0]  out_frame_class
);

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] kind_r, kind_nxt;
  logic [3:0]  hw_r, hw_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] daddr_r, daddr_nxt;
  logic [15:0] dport_r, dport_nxt;

  logic        out_valid_r;
  logic        out_pass_r;
  efaf_class_t out_class_r;

  logic        known;
  logic [7:0]  b;
  logic        last;
  logic [6:0]  l4;
  logic [15:0] port_hi_pos;
  logic [16:0] pos_p1;
  logic [16:0] need_tcp;
  logic [16:0] need_udp;
  logic        pass_v;
  efaf_class_t class_v;

  // True when the frame holds at least need bytes at known positions.
  function automatic logic has_bytes(input logic [16:0] have, input logic [16:0] need);
    has_bytes = (need <= have) && (need <= {1'b0, OFFSET_LIMIT});
  endfunction

  assign b    = head_item.frame_byte;
  assign last = head_item.end_of_frame;

  // A final byte needs the result register; other bytes always move on.
  assign pop = head_valid & (~last | ~out_valid_r | ~out_stall);

  assign known = (pos_r != OFFSET_LIMIT);

  // The header length is settled at offset 14, before any port byte position.
  assign l4          = 7'(ETH_HDR_LEN) + {1'b0, hw_r, 2'b00};
  assign port_hi_pos = {9'd0, l4} + 16'd2;
  assign pos_p1      = {1'b0, pos_r} + 17'd1;
  assign need_tcp    = {10'd0, l4} + {1'b0, TCP_HDR_LEN};
  assign need_udp    = {10'd0, l4} + {1'b0, UDP_HDR_LEN};

  always_comb begin
    kind_nxt  = kind_r;
    hw_nxt    = hw_r;
    proto_nxt = proto_r;
    daddr_nxt = daddr_r;
    dport_nxt = dport_r;
    pos_nxt   = pos_r;
    if (known) begin
      if (pos_r == POS_KIND_HI) kind_nxt = {b, kind_r[7:0]};
      if (pos_r == POS_KIND_LO) kind_nxt = {kind_r[15:8], b};
      if (pos_r == POS_IHL)     hw_nxt = b[3:0];
      if (pos_r == POS_PROTO)   proto_nxt = b;
      if (pos_r >= POS_DADDR_0 && pos_r <= POS_DADDR_3) begin
        daddr_nxt = {daddr_r[23:0], b};
      end
      if (pos_r == port_hi_pos)         dport_nxt = {b, dport_r[7:0]};
      if (pos_r == port_hi_pos + 16'd1) dport_nxt = {dport_r[15:8], b};
      pos_nxt = pos_r + 16'd1;
    end
  end

  always_comb begin
    pass_v  = 1'b0;
    class_v = CLASS_NON_IP;
    if (!has_bytes(pos_p1, {1'b0, ETH_HDR_LEN})) begin
      class_v = CLASS_NON_IP;
    end else if (kind_nxt == KIND_ARP) begin
      pass_v  = 1'b1;
      class_v = CLASS_ARP;
    end else if (kind_nxt != KIND_IPV4) begin
      class_v = CLASS_NON_IP;
    end else if (!has_bytes(pos_p1, {1'b0, ETH_HDR_LEN + IP_HDR_MIN})) begin
      class_v = CLASS_OTHER_IP;
    end else if (proto_nxt == PROTO_TCP) begin
      class_v = CLASS_TCP;
      pass_v  = has_bytes(pos_p1, need_tcp) && (daddr_nxt == cfg.allowed_address) &&
                (dport_nxt == cfg.allowed_port);
    end else if (proto_nxt == PROTO_UDP) begin
      class_v = CLASS_UDP;
      pass_v  = has_bytes(pos_p1, need_udp) && (daddr_nxt == cfg.allowed_address) &&
                (dport_nxt == DNS_PORT);
    end else begin
      class_v = CLASS_OTHER_IP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      kind_r      <= '0;
      hw_r        <= '0;
      proto_r     <= '0;
      daddr_r     <= '0;
      dport_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        if (last) begin
          pos_r   <= '0;
          kind_r  <= '0;
          hw_r    <= '0;
          proto_r <= '0;
          daddr_r <= '0;
          dport_r <= '0;
        end else begin
          pos_r   <= pos_nxt;
          kind_r  <= kind_nxt;
          hw_r    <= hw_nxt;
          proto_r <= proto_nxt;
          daddr_r <= daddr_nxt;
          dport_r <= dport_nxt;
        end
      end
      if (pop && last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && last) begin
      out_pass_r  <= pass_v;
      out_class_r <= class_v;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pass_frame  = out_pass_r;
  assign out_frame_class = out_class_r;

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && last) |=> (pos_r == 16'd0 && hw_r == 4'd0 && kind_r == 16'd0))
    else $error("frame state not cleared after the final byte");

  a_pass_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pass_r) |->
      (out_class_r == CLASS_ARP || out_class_r == CLASS_TCP || out_class_r == CLASS_UDP))
    else $error("frame passed with a class that never passes");

  a_ihl_after_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (hw_r != 4'd0) |-> (pos_r > POS_IHL))
    else $error("header length captured before its offset");

endmodule

[design/egress_frame_allow_filter.sv]
// Top level of the egress frame allow filter.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall  in_frame_byte, in_end_of_frame
//   out      output     out_valid/out_stall  out_pass_frame, out_frame_class
//   config   input      APB-style            allowed_address (0x0), allowed_port (0x4)
//
// One frame byte is accepted every clock cycle while in_stall is low; the header capture
// and the verdict sit in one pass between the input buffer and the result register.
// out_valid rises once the final byte leaves the input buffer while the result register
// is free or being taken; the verdict is held in the result register until it is taken.
// rst_n is synchronous and active low; it clears the frame state and both registers.
// An output stall only holds back final bytes; the two-entry input buffer raises in_stall
// from its own fill level, so the stall path is registered on both sides.
module egress_frame_allow_filter
  import efaf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_end_of_frame,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_pass_frame,
  output logic [2:0]  out_frame_class,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  efaf_cfg_t  cfg;
  efaf_item_t in_item;
  efaf_item_t head_item;
  logic       head_valid;
  logic       pop;

  assign in_item.frame_byte   = in_frame_byte;
  assign in_item.end_of_frame = in_end_of_frame;

  efaf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  efaf_in_buf u_in_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  efaf_parse u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .head_valid      (head_valid),
    .head_item       (head_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pass_frame  (out_pass_frame),
    .out_frame_class (out_frame_class)
  );

endmodule

[test/testbench.sv]
// Self-checking testbench for the egress frame allow filter.
module testbench;
  import efaf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_ALLOWED_ADDRESS = 3'h0;
  localparam logic [2:0] ADDR_ALLOWED_PORT    = 3'h4;
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    logic        forward;
    efaf_class_t cls;
  } verdict_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_frame_byte = 8'h00;
  logic        in_end_of_frame = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_pass_frame;
  logic [2:0]  out_frame_class;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  egress_frame_allow_filter uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_frame_byte   (in_frame_byte),
    .in_end_of_frame (in_end_of_frame),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pass_frame  (out_pass_frame),
    .out_frame_class (out_frame_class),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk = ~clk;

  // Filter state as the testbench sees it.
  logic [31:0] allow_addr = '0;
  logic [15:0] allow_port = '0;
  logic [15:0] frm_pos = '0;
  logic [15:0] frm_kind = '0;
  logic [3:0]  frm_ihl = '0;
  logic [7:0]  frm_proto = '0;
  logic [31:0] frm_daddr = '0;
  logic [15:0] frm_dport = '0;

  verdict_t    verdicts_due[$];
  logic [7:0]  frame_buf[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  int          hold_requests = 0;

  function automatic bit frame_holds(input int unsigned pos, input int unsigned need);
    return (need <= pos + 1) && (need <= OFFSET_LIMIT);
  endfunction

  function automatic void filter_step(input logic [7:0] b, input logic last,
                                      output bit produced, output verdict_t v);
    int unsigned pos;
    int unsigned l4;
    pos = frm_pos;
    // Once the offset saturates, a byte has no known position and captures nothing.
    if (frm_pos != OFFSET_LIMIT) begin
      if (pos == POS_KIND_HI) frm_kind[15:8] = b;
      if (pos == POS_KIND_LO) frm_kind[7:0] = b;
      if (pos == POS_IHL) frm_ihl = b[3:0];
      if (pos == POS_PROTO) frm_proto = b;
      if (pos >= POS_DADDR_0 && pos <= POS_DADDR_3) frm_daddr = {frm_daddr[23:0], b};
      l4 = ETH_HDR_LEN + 4 * frm_ihl;
      if (pos == l4 + 2) frm_dport[15:8] = b;
      if (pos == l4 + 3) frm_dport[7:0] = b;
      frm_pos = frm_pos + 16'd1;
    end
    l4 = ETH_HDR_LEN + 4 * frm_ihl;
    produced = last;
    v.forward = 1'b0;
    v.cls = CLASS_NON_IP;
    if (!last) return;
    if (!frame_holds(pos, ETH_HDR_LEN)) begin
      v.cls = CLASS_NON_IP;
    end else if (frm_kind == KIND_ARP) begin
      v.forward = 1'b1;
      v.cls = CLASS_ARP;
    end else if (frm_kind != KIND_IPV4) begin
      v.cls = CLASS_NON_IP;
    end else if (!frame_holds(pos, ETH_HDR_LEN + IP_HDR_MIN)) begin
      v.cls = CLASS_OTHER_IP;
    end else if (frm_proto == PROTO_TCP) begin
      v.cls = CLASS_TCP;
      v.forward = frame_holds(pos, l4 + TCP_HDR_LEN) && frm_daddr == allow_addr &&
                  frm_dport == allow_port;
    end else if (frm_proto == PROTO_UDP) begin
      v.cls = CLASS_UDP;
      v.forward = frame_holds(pos, l4 + UDP_HDR_LEN) && frm_daddr == allow_addr &&
                  frm_dport == DNS_PORT;
    end else begin
      v.cls = CLASS_OTHER_IP;
    end
    frm_pos = '0;
    frm_kind = '0;
    frm_ihl = '0;
    frm_proto = '0;
    frm_daddr = '0;
    frm_dport = '0;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Sends one byte; while gaps_on is set, the sender runs in bursts with idle gaps between them.
  task automatic send_byte(input logic [7:0] b, input logic last);
    bit       produced;
    verdict_t v;
    @(negedge clk);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_frame_byte <= b;
    in_end_of_frame <= last;
    do @(posedge clk); while (in_stall);
    filter_step(b, last, produced, v);
    if (produced) verdicts_due.push_back(v);
  endtask

  function automatic void put_byte(input int unsigned idx, input logic [7:0] val);
    if (idx < frame_buf.size()) frame_buf[idx] = val;
  endfunction

  // Builds a frame of random bytes with the given header fields, then sends it.
  // The port goes in first so that a short header length lets the IPv4 fields
  // overwrite it, as on a real wire.
  task automatic send_frame(input logic [15:0] kind, input logic [3:0] ihl,
                            input logic [7:0] proto, input logic [31:0] daddr,
                            input logic [15:0] dport, input int unsigned len);
    int unsigned l4;
    frame_buf.delete();
    repeat (len) frame_buf.push_back(8'($urandom));
    l4 = ETH_HDR_LEN + 4 * ihl;
    put_byte(l4 + 2, dport[15:8]);
    put_byte(l4 + 3, dport[7:0]);
    put_byte(POS_KIND_HI, kind[15:8]);
    put_byte(POS_KIND_LO, kind[7:0]);
    put_byte(POS_IHL, {4'($urandom), ihl});
    put_byte(POS_PROTO, proto);
    for (int k = 0; k < 4; k++) put_byte(POS_DADDR_0 + k, daddr[31 - 8 * k -: 8]);
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_ALLOWED_ADDRESS) allow_addr = data;
    else if (addr == ADDR_ALLOWED_PORT) allow_port = data[15:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Stops sending and waits for every outstanding verdict, then lets the pipeline settle.
  task automatic drain_verdicts();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_filter(input logic [31:0] addr, input logic [15:0] port);
    drain_verdicts();
    write_register(ADDR_ALLOWED_ADDRESS, addr);
    write_register(ADDR_ALLOWED_PORT, {16'h0, port});
  endtask

  task automatic send_random_frame();
    logic [15:0] kind;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] daddr;
    logic [15:0] dport;
    int unsigned need;
    int unsigned len;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) kind = KIND_ARP;
    else if (r < 80) kind = KIND_IPV4;
    else if (r < 90) kind = 16'h86DD;
    else kind = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 40) proto = PROTO_TCP;
    else if (r < 80) proto = PROTO_UDP;
    else proto = 8'($urandom);
    ihl = ($urandom_range(0, 99) < 60) ? 4'd5 : 4'($urandom);
    daddr = ($urandom_range(0, 99) < 70) ? allow_addr : $urandom;
    if ($urandom_range(0, 99) < 70) dport = (proto == PROTO_UDP) ? DNS_PORT : allow_port;
    else dport = 16'($urandom);
    need = ETH_HDR_LEN + 4 * ihl + ((proto == PROTO_UDP) ? UDP_HDR_LEN : TCP_HDR_LEN);
    if (need < ETH_HDR_LEN + IP_HDR_MIN) need = ETH_HDR_LEN + IP_HDR_MIN;
    if ($urandom_range(0, 99) < 80) len = need + $urandom_range(0, 12);
    else len = $urandom_range(1, need);
    gaps_on = ($urandom_range(0, 3) != 0);
    send_frame(kind, ihl, proto, daddr, dport, len);
  endtask

  task automatic test_directed_frames();
    logic [31:0] a;
    logic [15:0] p;
    a = $urandom;
    p = 16'($urandom);
    set_filter(a, p);
    gaps_on = 1'b1;
    send_frame(KIND_ARP, 4'd5, PROTO_TCP, a, p, 14);
    send_frame(KIND_ARP, 4'd5, PROTO_TCP, a, p, 13);
    send_frame(KIND_ARP, 4'd5, PROTO_TCP, a, p, 1);
    send_frame(16'h86DD, 4'd5, PROTO_TCP, a, p, 20);
    send_frame(KIND_IPV4, 4'd5, PROTO_TCP, a, p, 33);
    send_frame(KIND_IPV4, 4'd5, 8'd1, a, p, 34);
    send_frame(KIND_IPV4, 4'd5, PROTO_TCP, a, p, 54);
    send_frame(KIND_IPV4, 4'd5, PROTO_TCP, a, p, 53);
    send_frame(KIND_IPV4, 4'd5, PROTO_TCP, a, p ^ 16'h0001, 54);
    send_frame(KIND_IPV4, 4'd5, PROTO_UDP, a, DNS_PORT, 42);
    send_frame(KIND_IPV4, 4'd5, PROTO_UDP, a, DNS_PORT, 41);
    // Header lengths below five put the port inside the IPv4 header.
    send_frame(KIND_IPV4, 4'd0, PROTO_TCP, a, p, 34);
    send_frame(KIND_IPV4, 4'd4, PROTO_UDP, a, DNS_PORT, 40);
  endtask

  // The receiver holds off while short frames keep coming, so the input stalls.
  task automatic test_output_backpressure();
    drain_verdicts();
    hold_requests++;
    @(negedge clk);
    gaps_on = 1'b0;
    repeat (10) send_frame(KIND_ARP, 4'd5, PROTO_TCP, allow_addr, allow_port,
                           $urandom_range(1, 3));
    drain_verdicts();
  endtask

  task automatic test_random_traffic(input logic [31:0] addr, input logic [15:0] port);
    int frames;
    int bytes_sent;
    frames = 0;
    bytes_sent = 0;
    set_filter(addr, port);
    while (frames < 1 || bytes_sent < 30) begin
      send_random_frame();
      frames++;
      bytes_sent += frame_buf.size();
    end
  endtask

  // Receiver stall pattern, with a long hold-off on request.
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: out_stall <= (mode_left % 3 == 0);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin : check_verdicts
    verdict_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("verdict transaction with no frame outstanding");
      end else begin
        due = verdicts_due.pop_front();
        if (out_pass_frame !== due.forward)
          report_mismatch($sformatf("pass_frame %b, expected %b", out_pass_frame,
                                    due.forward));
        if (out_frame_class !== due.cls)
          report_mismatch($sformatf("frame_class %0d, expected %0d (%s)", out_frame_class,
                                    due.cls, due.cls.name()));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_frames();
    test_output_backpressure();
    test_random_traffic(32'h0000_0000, 16'h0000);
    test_random_traffic(32'hFFFF_FFFF, 16'hFFFF);
    test_random_traffic($urandom, DNS_PORT);
    test_random_traffic($urandom, 16'($urandom));
    test_random_traffic($urandom, 16'($urandom));
    drain_verdicts();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
